// ===== rtl/core/pru_pkg.sv =====
// Shared types and constants for the pixel replicate upscaler.
// Used by every module of the block but pru_ram; depends on nothing else.
`timescale 1ns / 1ps

package pru_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int STORE_AW    = $clog2(MAX_WIDTH);
    localparam int PIX_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [6:0]  SCALE_LIMIT = 7'd100;
    localparam logic [11:0] WIDTH_LIMIT = 12'(MAX_WIDTH);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_PUSH_OK      = 2'd0,
        ST_PUSH_REFUSED = 2'd1,
        ST_PIXEL        = 2'd2,
        ST_EMPTY        = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic       row_last;
        logic [1:0] pad_bytes;
        logic       frame_last;
    } t_meta;

    typedef struct packed {
        t_meta              meta;
        logic [PIX_W-1:0]   pixel;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [STORE_AW-1:0]  waddr;
        logic [PIX_W-1:0]     wdata;
        logic                 re;
        logic [STORE_AW-1:0]  raddr;
    } t_ram_req;

endpackage

// ===== rtl/core/pixel_replicate_upscaler.sv =====
// Top level of the pixel replicate upscaler: configuration registers and
// the connection of front end, line store and back end. Depends on pru_pkg, pru_front, pru_ram and pru_back.
`timescale 1ns / 1ps

// Usage
// Every input request is a push (store one source pixel of the current row)
// or a pull (take the next pixel of the enlarged image); each request gives
// exactly one result on the output channel, in order. Requests are taken on
// i_valid with o_stall low; results leave on o_valid with i_stall low.
// A request is accepted every cycle as long as the four-entry result queue
// has room. A result passes the registered line store read and then enters
// the queue before it leaves on the output channel. When the receiver
// stalls, results pile up in the queue and o_stall rises only once the
// queue and the read stage together hold four results; the output payload
// holds while stalled. Reset clears all counters, the queue and the
// registers (scale, width and height return to one); line store contents
// are not cleared and need not be, since an entry is read only after the
// current row has written it. Registers are written over the APB port and
// should only change while no request is in flight.

module pixel_replicate_upscaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_row_last,
    output logic [1:0]  o_pad_bytes,
    output logic        o_frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pru_pkg::*;

    logic [6:0]  r_scale;
    logic [11:0] r_width;
    logic [15:0] r_height;

    logic        cfg_write;
    logic        room;
    logic        issue;
    t_meta       meta;
    t_ram_req    ram_req;
    logic [PIX_W-1:0] rdata;
    t_result     result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 7'd1;
            r_width  <= 12'd1;
            r_height <= 16'd1;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SCALE:  r_scale  <= pwdata[6:0];
                REG_WIDTH:  r_width  <= pwdata[11:0];
                REG_HEIGHT: r_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCALE:  prdata = {25'd0, r_scale};
            REG_WIDTH:  prdata = {20'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    pru_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_opcode),
        .i_pixel  ({i_red_in, i_green_in, i_blue_in}),
        .i_room   (room),
        .i_scale  (r_scale),
        .i_width  (r_width),
        .i_height (r_height),
        .o_issue  (issue),
        .o_meta   (meta),
        .o_ram    (ram_req)
    );

    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    pru_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_meta   (meta),
        .i_rdata  (rdata),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    assign o_status     = result.meta.status;
    assign o_red_out    = result.pixel[23:16];
    assign o_green_out  = result.pixel[15:8];
    assign o_blue_out   = result.pixel[7:0];
    assign o_row_last   = result.meta.row_last;
    assign o_pad_bytes  = result.meta.pad_bytes;
    assign o_frame_last = result.meta.frame_last;

endmodule

// ===== rtl/core/pru_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pru_front.sv =====
// Front end: accepts requests, classifies push and pull, keeps all row and
// frame counters and issues line store accesses. Depends on pru_pkg.
`timescale 1ns / 1ps

module pru_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [pru_pkg::PIX_W-1:0] i_pixel,
    input  logic                  i_room,
    input  logic [6:0]            i_scale,
    input  logic [11:0]           i_width,
    input  logic [15:0]           i_height,
    output logic                  o_issue,
    output pru_pkg::t_meta        o_meta,
    output pru_pkg::t_ram_req     o_ram
);
    import pru_pkg::*;

    logic        r_row_ready, n_row_ready;
    logic [11:0] r_fill, n_fill;
    logic [10:0] r_send, n_send;
    logic [6:0]  r_copy, n_copy;
    logic [6:0]  r_repeat, n_repeat;
    logic [15:0] r_row, n_row;

    logic        accept;
    logic [6:0]  s_eff;
    logic [11:0] w_eff;
    logic [15:0] h_eff;
    logic [3:0]  prod;
    logic [3:0]  bytes_low;
    logic [11:0] fill_inc;
    logic        last_copy, last_col, last_rep, last_row;

    assign accept  = i_valid && i_room;
    assign o_stall = !i_room;
    assign o_issue = accept;

    always_comb begin
        if (i_scale == 7'd0) begin
            s_eff = 7'd1;
        end else if (i_scale > SCALE_LIMIT) begin
            s_eff = SCALE_LIMIT;
        end else begin
            s_eff = i_scale;
        end
        if (i_width == 12'd0) begin
            w_eff = 12'd1;
        end else if (i_width > WIDTH_LIMIT) begin
            w_eff = WIDTH_LIMIT;
        end else begin
            w_eff = i_width;
        end
        h_eff = (i_height == 16'd0) ? 16'd1 : i_height;
    end

    // Only the low two bits of 3*scale*width decide the row padding.
    assign prod      = {2'b00, s_eff[1:0]} * {2'b00, w_eff[1:0]};
    assign bytes_low = prod + {prod[2:0], 1'b0};

    assign fill_inc  = r_fill + 12'd1;
    assign last_copy = ({1'b0, r_copy} + 8'd1) >= {1'b0, s_eff};
    assign last_col  = ({1'b0, r_send} + 12'd1) >= w_eff;
    assign last_rep  = ({1'b0, r_repeat} + 8'd1) >= {1'b0, s_eff};
    assign last_row  = ({1'b0, r_row} + 17'd1) >= {1'b0, h_eff};

    always_comb begin
        n_row_ready = r_row_ready;
        n_fill      = r_fill;
        n_send      = r_send;
        n_copy      = r_copy;
        n_repeat    = r_repeat;
        n_row       = r_row;
        o_meta      = '0;
        o_ram       = '0;
        o_ram.waddr = r_fill[STORE_AW-1:0];
        o_ram.wdata = i_pixel;
        o_ram.raddr = r_send[STORE_AW-1:0];

        if (i_opcode == OP_PUSH) begin
            if (r_row_ready) begin
                o_meta.status = ST_PUSH_REFUSED;
            end else begin
                o_meta.status = ST_PUSH_OK;
                o_ram.we      = accept;
                n_fill        = fill_inc;
                if (fill_inc >= w_eff || fill_inc == 12'd0) begin
                    n_fill      = 12'd0;
                    n_row_ready = 1'b1;
                    n_send      = 11'd0;
                    n_copy      = 7'd0;
                    n_repeat    = 7'd0;
                end
            end
        end else if (!r_row_ready) begin
            o_meta.status = ST_EMPTY;
        end else begin
            o_meta.status = ST_PIXEL;
            o_ram.re      = accept;
            if (!last_copy) begin
                n_copy = r_copy + 7'd1;
            end else begin
                n_copy = 7'd0;
                if (!last_col) begin
                    n_send = r_send + 11'd1;
                end
            end
            if (last_copy && last_col) begin
                o_meta.row_last  = 1'b1;
                o_meta.pad_bytes = 2'(4'd0 - bytes_low);
                n_send           = 11'd0;
                if (last_rep) begin
                    n_repeat    = 7'd0;
                    n_row_ready = 1'b0;
                    if (last_row) begin
                        o_meta.frame_last = 1'b1;
                        n_row             = 16'd0;
                    end else begin
                        n_row = r_row + 16'd1;
                    end
                end else begin
                    n_repeat = r_repeat + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ready <= 1'b0;
            r_fill      <= 12'd0;
            r_send      <= 11'd0;
            r_copy      <= 7'd0;
            r_repeat    <= 7'd0;
            r_row       <= 16'd0;
        end else if (accept) begin
            r_row_ready <= n_row_ready;
            r_fill      <= n_fill;
            r_send      <= n_send;
            r_copy      <= n_copy;
            r_repeat    <= n_repeat;
            r_row       <= n_row;
        end
    end

endmodule

// ===== rtl/core/pru_back.sv =====
// Back end: joins the staged result flags with the line store read data and
// queues finished results for the output channel. Depends on pru_pkg.
`timescale 1ns / 1ps

module pru_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_issue,
    input  pru_pkg::t_meta            i_meta,
    input  logic [pru_pkg::PIX_W-1:0] i_rdata,
    output logic                      o_room,
    output logic                      o_valid,
    input  logic                      i_stall,
    output pru_pkg::t_result          o_result
);
    import pru_pkg::*;

    logic                r_stage_valid;
    t_meta               r_stage_meta;
    t_result             r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_head, r_tail;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                push, pop;
    t_result             stage_result;

    // Pixel bytes read zero unless the result actually gives a pixel.
    always_comb begin
        stage_result.meta  = r_stage_meta;
        stage_result.pixel = (r_stage_meta.status == ST_PIXEL) ? i_rdata : '0;
    end

    assign push    = r_stage_valid;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign n_count = r_count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);

    // The item held in the stage register already owns a queue slot.
    assign o_room  = ((QUEUE_AW+1)'(r_count) + (QUEUE_AW+1)'(r_stage_valid))
                     < (QUEUE_AW+1)'(QUEUE_DEPTH);

    assign o_result = r_queue[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
        end else begin
            r_stage_valid <= i_issue;
            r_count       <= n_count;
            if (push) begin
                r_tail <= r_tail + QUEUE_AW'(1);
            end
            if (pop) begin
                r_head <= r_head + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_stage_meta <= i_meta;
        end
        if (push) begin
            r_queue[r_tail] <= stage_result;
        end
    end

endmodule

// ===== rtl/core/pru_checker.sv =====
// Port-level checks for the pixel replicate upscaler, bound to the top level.
// Depends on pru_pkg.
`timescale 1ns / 1ps

module pru_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_status,
    input  logic [7:0]  o_red_out,
    input  logic [7:0]  o_green_out,
    input  logic [7:0]  o_blue_out,
    input  logic        o_row_last,
    input  logic [1:0]  o_pad_bytes,
    input  logic        o_frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready
);
    import pru_pkg::*;

    // Padding is only reported at the end of an output row.
    a_pad_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pad_bytes != 2'd0) |-> o_row_last)
        else $error("pad bytes reported away from row end");

    // The frame ends on the last pixel of a row.
    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |-> o_row_last && (o_status == ST_PIXEL))
        else $error("frame end without row end pixel");

    // Anything but a given pixel carries zero payload.
    a_zero_without_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_PIXEL) |->
            (o_red_out == 8'd0) && (o_green_out == 8'd0) && (o_blue_out == 8'd0)
            && !o_row_last && !o_frame_last)
        else $error("nonzero payload on a result without a pixel");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_row_last)
            && $stable(o_pad_bytes) && $stable(o_frame_last))
        else $error("stalled result changed");

endmodule

bind pixel_replicate_upscaler pru_checker u_pru_checker (.*);
